[src/tla_pkg.sv]
// Shared constants and types for the terminal line assembler.
package tla_pkg;

  localparam int DEF_MAX_COLUMNS    = 64;
  localparam int DEF_MAX_SCROLLBACK = 128;

  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CHAR_W-1:0] KEY_CR     = 8'd13;
  localparam logic [CHAR_W-1:0] KEY_LF     = 8'd10;
  localparam logic [CHAR_W-1:0] KEY_BS     = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_ATTR = 8'h0F;

  localparam logic [6:0] RST_COLUMNS    = 7'd60;
  localparam logic       RST_ATTR_MODE  = 1'b0;
  localparam logic [3:0] RST_FORE       = 4'd15;
  localparam logic [3:0] RST_BACK       = 4'd0;
  localparam logic [7:0] RST_SCROLLBACK = 8'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS    = 3'd0,
    CFG_ATTR_MODE  = 3'd1,
    CFG_FORE       = 3'd2,
    CFG_BACK       = 3'd3,
    CFG_SCROLLBACK = 3'd4
  } cfg_reg_t;

endpackage

[src/tla_channels.sv]
// Valid/ready channel interfaces for the terminal line assembler.
interface tla_in_if;
  logic                      valid;
  logic                      ready;
  logic [tla_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface tla_out_if #(
  parameter int MAX_COLUMNS    = tla_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_SCROLLBACK = tla_pkg::DEF_MAX_SCROLLBACK
);
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int CUR_W  = $clog2(MAX_COLUMNS + 1);
  localparam int SLOT_W = $clog2(MAX_SCROLLBACK);
  localparam int LINE_W = $clog2(MAX_SCROLLBACK + 1);

  logic                       valid;
  logic                       ready;
  logic                       status;
  logic                       write_valid;
  logic [SLOT_W-1:0]          ring_slot;
  logic [COL_W-1:0]           cell_column;
  logic [tla_pkg::CHAR_W-1:0] cell_char;
  logic [tla_pkg::CHAR_W-1:0] cell_attr;
  logic [LINE_W-1:0]          lines_held;
  logic [CUR_W-1:0]           cursor_column;
  logic                       last_of_run;

  modport source (output valid, output status, output write_valid, output ring_slot,
                  output cell_column, output cell_char, output cell_attr,
                  output lines_held, output cursor_column, output last_of_run,
                  input ready);
  modport sink   (input valid, input status, input write_valid, input ring_slot,
                  input cell_column, input cell_char, input cell_attr,
                  input lines_held, input cursor_column, input last_of_run,
                  output ready);
endinterface

interface tla_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tla_pkg::CFG_IDX_W-1:0]  index;
  logic [tla_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/terminal_line_assembler_core.sv]
// Terminal line assembler: line buffer memories, commit walker and output register.
// Plain characters and backspaces each give a single registered result, shown in the
// cycle after the item is accepted.
// A line commit emits one cell per cycle from the line memories (registered read) while
// the output is not stalled; no new item is taken until every column in use is emitted.
// Reset is synchronous and active low; per-column valid bits make the whole line read as
// blanks at once, so no clearing pass follows reset or a commit.
module terminal_line_assembler_core #(
  parameter int MAX_COLUMNS    = tla_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_SCROLLBACK = tla_pkg::DEF_MAX_SCROLLBACK
) (
  input  logic          clk,
  input  logic          rst_n,
  tla_in_if.sink        in_if,
  tla_out_if.source     out_if,
  tla_cfg_if.sink       cfg_if
);

  localparam int IDX_W  = $clog2(MAX_COLUMNS);
  localparam int CUR_W  = $clog2(MAX_COLUMNS + 1);
  localparam int SLOT_W = $clog2(MAX_SCROLLBACK);
  localparam int LINE_W = $clog2(MAX_SCROLLBACK + 1);
  localparam int CW     = tla_pkg::CHAR_W;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [6:0] columns_r;
  logic       attr_mode_r;
  logic [3:0] fore_r;
  logic [3:0] back_r;
  logic [7:0] scrollback_r;

  // Line state.
  logic [CUR_W-1:0]  cursor_r;
  logic [LINE_W-1:0] line_total_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] walk_slot_r;
  logic [IDX_W-1:0]  cnt_r;
  logic [CW-1:0]     clear_attr_r;

  // Line memories and their per-column valid bits.
  logic [CW-1:0]          chars_mem [MAX_COLUMNS];
  logic [CW-1:0]          attrs_mem [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] char_vld_r;
  logic [MAX_COLUMNS-1:0] attr_vld_r;
  logic [CW-1:0]          rd_char_r;
  logic [CW-1:0]          rd_attr_r;
  logic                   rd_cvld_r;
  logic                   rd_avld_r;

  // Output register.
  logic              out_valid_r;
  logic              out_status_r;
  logic              out_wv_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [IDX_W-1:0]  out_col_r;
  logic [CW-1:0]     out_char_r;
  logic [CW-1:0]     out_attr_r;
  logic [LINE_W-1:0] out_lines_r;
  logic [CUR_W-1:0]  out_cursor_r;
  logic              out_last_r;

  logic [CW-1:0]     colors;
  logic [CUR_W-1:0]  cols_eff;
  logic [IDX_W-1:0]  cols_m1;
  logic [LINE_W-1:0] sb_eff;
  logic              out_free;
  logic              in_fire;
  logic              cfg_fire;
  logic              emit_fire;
  logic              out_load;
  logic              walk_last;
  logic [CW-1:0]     code;
  logic              is_bs;
  logic              is_commit;
  logic              wr_en;
  logic              wr_attr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [CW-1:0]     wr_char;
  logic [IDX_W-1:0]  rd_addr;
  logic [CUR_W-1:0]  cursor_nxt;
  logic [LINE_W:0]   line_inc;
  logic [LINE_W-1:0] line_total_nxt;
  logic [LINE_W-1:0] slot_inc;
  logic [SLOT_W-1:0] slot_nxt;
  logic [CW-1:0]     cell_char;
  logic [CW-1:0]     cell_attr;

  assign colors = {back_r, fore_r};

  always_comb begin
    if (columns_r == '0) begin
      cols_eff = CUR_W'(1);
    end else if (32'(columns_r) > MAX_COLUMNS) begin
      cols_eff = CUR_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CUR_W'(columns_r);
    end
    if (scrollback_r < 8'd2) begin
      sb_eff = LINE_W'(2);
    end else if (32'(scrollback_r) > MAX_SCROLLBACK) begin
      sb_eff = LINE_W'(MAX_SCROLLBACK);
    end else begin
      sb_eff = LINE_W'(scrollback_r);
    end
  end

  assign cols_m1 = IDX_W'(cols_eff - CUR_W'(1));

  assign out_free  = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_fire  = cfg_if.valid;
  assign emit_fire = (state_r == ST_WALK) && out_free;
  assign walk_last = (cnt_r == cols_m1);

  assign code      = in_if.char_code;
  assign is_bs     = (code == tla_pkg::KEY_BS);
  assign is_commit = (cursor_r >= cols_eff) || (code == tla_pkg::KEY_CR) ||
                     (code == tla_pkg::KEY_LF);
  assign out_load  = (in_fire && !is_commit) || emit_fire;

  // A backspace at column 0 writes nothing.
  assign wr_en      = in_fire && !is_commit && (!is_bs || (cursor_r != '0));
  assign wr_attr_en = wr_en && attr_mode_r;
  assign wr_idx     = IDX_W'(cursor_r);
  assign wr_char    = is_bs ? tla_pkg::CHAR_SPACE : code;

  // The read address runs one ahead when a cell leaves, so the read register always
  // holds the cell that cnt_r points at.
  assign rd_addr = emit_fire ? IDX_W'(cnt_r + IDX_W'(1)) : cnt_r;

  always_comb begin
    if (is_bs) begin
      cursor_nxt = (cursor_r != '0) ? cursor_r - CUR_W'(1) : cursor_r;
    end else begin
      cursor_nxt = cursor_r + CUR_W'(1);
    end
  end

  assign line_inc       = {1'b0, line_total_r} + (LINE_W+1)'(1);
  assign line_total_nxt = (line_inc >= {1'b0, sb_eff}) ? sb_eff : line_inc[LINE_W-1:0];
  assign slot_inc       = LINE_W'(slot_r) + LINE_W'(1);
  assign slot_nxt       = (slot_inc >= sb_eff) ? '0 : SLOT_W'(slot_inc);

  assign cell_char = rd_cvld_r ? rd_char_r : tla_pkg::CHAR_SPACE;
  assign cell_attr = !attr_mode_r ? '0 : (rd_avld_r ? rd_attr_r : clear_attr_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      chars_mem[wr_idx] <= wr_char;
    end
    if (wr_attr_en) begin
      attrs_mem[wr_idx] <= colors;
    end
    rd_char_r <= chars_mem[rd_addr];
    rd_attr_r <= attrs_mem[rd_addr];
    rd_cvld_r <= char_vld_r[rd_addr];
    rd_avld_r <= attr_vld_r[rd_addr];
  end

  // Clearing every valid bit at the end of a walk blanks the whole line at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_vld_r <= '0;
      attr_vld_r <= '0;
    end else if (emit_fire && walk_last) begin
      char_vld_r <= '0;
      attr_vld_r <= '0;
    end else begin
      if (wr_en) begin
        char_vld_r[wr_idx] <= 1'b1;
      end
      if (wr_attr_en) begin
        attr_vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      cursor_r     <= '0;
      line_total_r <= LINE_W'(1);
      slot_r       <= '0;
      cnt_r        <= '0;
      clear_attr_r <= tla_pkg::RESET_ATTR;
      columns_r    <= tla_pkg::RST_COLUMNS;
      attr_mode_r  <= tla_pkg::RST_ATTR_MODE;
      fore_r       <= tla_pkg::RST_FORE;
      back_r       <= tla_pkg::RST_BACK;
      scrollback_r <= tla_pkg::RST_SCROLLBACK;
    end else begin
      if (cfg_fire) begin
        unique case (tla_pkg::cfg_reg_t'(cfg_if.index))
          tla_pkg::CFG_COLUMNS:    columns_r    <= cfg_if.data[6:0];
          tla_pkg::CFG_ATTR_MODE:  attr_mode_r  <= cfg_if.data[0];
          tla_pkg::CFG_FORE:       fore_r       <= cfg_if.data[3:0];
          tla_pkg::CFG_BACK:       back_r       <= cfg_if.data[3:0];
          tla_pkg::CFG_SCROLLBACK: scrollback_r <= cfg_if.data[7:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.valid && out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (is_commit) begin
              state_r      <= ST_WALK;
              cursor_r     <= '0;
              line_total_r <= line_total_nxt;
              slot_r       <= slot_nxt;
              walk_slot_r  <= slot_r;
            end else begin
              cursor_r     <= cursor_nxt;
              out_status_r <= 1'b0;
              out_wv_r     <= 1'b0;
              out_slot_r   <= slot_r;
              out_col_r    <= '0;
              out_char_r   <= '0;
              out_attr_r   <= '0;
              out_lines_r  <= line_total_r;
              out_cursor_r <= cursor_nxt;
              out_last_r   <= 1'b1;
            end
          end
        end
        ST_WALK: begin
          if (emit_fire) begin
            out_status_r <= 1'b1;
            out_wv_r     <= 1'b1;
            out_slot_r   <= walk_slot_r;
            out_col_r    <= cnt_r;
            out_char_r   <= cell_char;
            out_attr_r   <= cell_attr;
            out_lines_r  <= line_total_r;
            out_cursor_r <= cursor_r;
            out_last_r   <= walk_last;
            if (walk_last) begin
              state_r      <= ST_IDLE;
              cnt_r        <= '0;
              clear_attr_r <= colors;
            end else begin
              cnt_r <= cnt_r + IDX_W'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_status_r;
  assign out_if.write_valid   = out_wv_r;
  assign out_if.ring_slot     = out_slot_r;
  assign out_if.cell_column   = out_col_r;
  assign out_if.cell_char     = out_char_r;
  assign out_if.cell_attr     = out_attr_r;
  assign out_if.lines_held    = out_lines_r;
  assign out_if.cursor_column = out_cursor_r;
  assign out_if.last_of_run   = out_last_r;

  a_commit_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_commit |=> state_r == ST_WALK && cursor_r == '0)
    else $error("commit did not start a walk with the cursor at column zero");

  a_walk_ends_clean: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire && walk_last |=> state_r == ST_IDLE && cnt_r == '0 &&
                               char_vld_r == '0 && attr_vld_r == '0)
    else $error("line walk ended without returning to idle with a blank line");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CUR_W'(MAX_COLUMNS))
    else $error("cursor ran past the end of the line buffer");

  a_plain_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_status_r |-> out_last_r && !out_wv_r)
    else $error("plain item result is not a single non-write result");

endmodule
